// ----- rtl/lfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types, register codes and the CRC-8 helper for the link frame
// receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // default maximum frame size in bytes, address and crc included
  localparam int MAX_FRAME_BYTES_DEF = 64;

  // configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_FC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_AIR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_RX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_TX  = 2'd3;

  // register reset values
  localparam logic [7:0] ADDR_FC_RST  = 8'd200;
  localparam logic [7:0] ADDR_AIR_RST = 8'd234;
  localparam logic [7:0] ADDR_RX_RST  = 8'd236;
  localparam logic [7:0] ADDR_TX_RST  = 8'd238;

  // smallest accepted length byte
  localparam logic [8:0] MIN_LEN = 9'd2;

  // CRC-8, polynomial 0xD5, MSB first
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // one result transfer
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic        crc_error;
    logic [15:0] bad_frame_count;
  } res_t;

  // one byte of CRC-8, eight shift steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lfr_addr_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_addr_filter
// Holds the four accepted start addresses and flags a received byte that
// matches any of them.
// ----------------------------------------------------------------------------
module lfr_addr_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [7:0]                    rx_byte,
  output logic                               addr_hit
);
  import lfr_pkg::*;

  logic [7:0] addr_fc;
  logic [7:0] addr_air;
  logic [7:0] addr_rx;
  logic [7:0] addr_tx;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_fc  <= ADDR_FC_RST;
      addr_air <= ADDR_AIR_RST;
      addr_rx  <= ADDR_RX_RST;
      addr_tx  <= ADDR_TX_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ADDR_FC:  addr_fc  <= cfg_data;
        REG_ADDR_AIR: addr_air <= cfg_data;
        REG_ADDR_RX:  addr_rx  <= cfg_data;
        REG_ADDR_TX:  addr_tx  <= cfg_data;
        default:      ;
      endcase
    end
  end

  // address compare
  assign addr_hit = (rx_byte == addr_fc) || (rx_byte == addr_air) ||
                    (rx_byte == addr_rx) || (rx_byte == addr_tx);

endmodule
`default_nettype wire

// ----- rtl/lfr_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_out_stage
// Output register: holds one result until the downstream side takes it,
// and reports when a new result may be loaded.
// ----------------------------------------------------------------------------
module lfr_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire lfr_pkg::res_t res,
  output logic               free,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         frame_byte,
  output logic [5:0]         byte_index,
  output logic               last,
  output logic               crc_error,
  output logic [15:0]        bad_frame_count
);
  import lfr_pkg::*;

  res_t hold;

  // empty, or emptied by a transfer this cycle
  assign free = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      hold <= res;
    end
  end

  assign frame_byte      = hold.frame_byte;
  assign byte_index      = hold.byte_index;
  assign last            = hold.last;
  assign crc_error       = hold.crc_error;
  assign bad_frame_count = hold.bad_frame_count;

endmodule
`default_nettype wire

// ----- rtl/link_frame_receiver_crc8.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// link_frame_receiver_crc8
// Byte-wise frame receiver: address filter, length check, frame buffer in a
// synchronous RAM, CRC-8 check and byte-by-byte output of good frames.
// ----------------------------------------------------------------------------
// Receive: one byte a cycle while in_stall is low; the CRC is updated with each
//   payload byte written, not with the address, length or crc byte.
// Good frame: per byte, RAM read then output load; input stalled meanwhile.
// Bad frame: one error result, loaded once the output register is free.
// Reset: control state, counter and address registers cleared to defaults;
//   the frame RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module link_frame_receiver_crc8 #(
  parameter int MAX_FRAME_BYTES = lfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         frame_byte,
  output logic [5:0]                         byte_index,
  output logic                               last,
  output logic                               crc_error,
  output logic [15:0]                        bad_frame_count
);
  import lfr_pkg::*;

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [8:0] MAX_LEN = 9'(MAX_FRAME_BYTES - 2);

  typedef enum logic [3:0] {
    ST_RX  = 4'b0001,
    ST_ERR = 4'b0010,
    ST_RD  = 4'b0100,
    ST_LD  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] needed, needed_next;
  logic [PW-1:0] rd_cnt, rd_cnt_next;
  logic [7:0]    crc, crc_next;
  logic [15:0]   bad_frames, bad_next;

  logic          addr_hit;
  logic          in_acc;
  logic          len_bad;
  logic [PW-1:0] len_needed;
  logic [PW-1:0] pos_inc;
  logic          last_byte;
  logic [PW+5:0] idx_wide;

  logic          wr_en;
  logic          rd_en;
  logic [7:0]    rd_data;
  logic [7:0]    frame_mem [MAX_FRAME_BYTES];

  logic          ld_out;
  logic          out_free;
  res_t          res;

  lfr_addr_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .addr_hit  (addr_hit)
  );

  // input handshake
  assign in_stall = (state != ST_RX);
  assign in_acc   = in_valid && !in_stall;

  // length decode and position arithmetic
  assign len_bad    = ({1'b0, rx_byte} < MIN_LEN) || ({1'b0, rx_byte} > MAX_LEN);
  assign len_needed = PW'({1'b0, rx_byte} + MIN_LEN);
  assign pos_inc    = pos + PW'(1);
  assign last_byte  = (rd_cnt + PW'(1)) == needed;
  assign idx_wide   = {6'b0, rd_cnt};

  // sequencer
  always_comb begin
    state_next  = state;
    pos_next    = pos;
    needed_next = needed;
    rd_cnt_next = rd_cnt;
    crc_next    = crc;
    bad_next    = bad_frames;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    ld_out      = 1'b0;
    res         = '0;
    unique case (state)
      ST_RX: begin
        if (in_acc) begin
          if (pos == '0) begin
            if (addr_hit) begin
              wr_en    = 1'b1;
              pos_next = PW'(1);
              crc_next = '0;
            end
          end else if (pos == PW'(1)) begin
            if (len_bad) begin
              pos_next = '0;
            end else begin
              wr_en       = 1'b1;
              pos_next    = PW'(2);
              needed_next = len_needed;
              crc_next    = '0;
            end
          end else begin
            wr_en = 1'b1;
            if (pos_inc < needed) begin
              crc_next = crc8_update(crc, rx_byte);
              pos_next = pos_inc;
            end else begin
              pos_next    = '0;
              rd_cnt_next = '0;
              state_next  = (crc == rx_byte) ? ST_RD : ST_ERR;
            end
          end
        end
      end
      ST_ERR: begin
        res.last            = 1'b1;
        res.crc_error       = 1'b1;
        res.bad_frame_count = bad_frames + 16'd1;
        if (out_free) begin
          ld_out     = 1'b1;
          bad_next   = bad_frames + 16'd1;
          state_next = ST_RX;
        end
      end
      ST_RD: begin
        rd_en      = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        res.frame_byte      = rd_data;
        res.byte_index      = idx_wide[5:0];
        res.last            = last_byte;
        res.bad_frame_count = bad_frames;
        if (out_free) begin
          ld_out = 1'b1;
          if (last_byte) begin
            state_next = ST_RX;
          end else begin
            rd_cnt_next = rd_cnt + PW'(1);
            state_next  = ST_RD;
          end
        end
      end
      default: state_next = ST_RX;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RX;
      pos        <= '0;
      needed     <= '0;
      rd_cnt     <= '0;
      crc        <= '0;
      bad_frames <= '0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      needed     <= needed_next;
      rd_cnt     <= rd_cnt_next;
      crc        <= crc_next;
      bad_frames <= bad_next;
    end
  end

  // frame RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[pos[AW-1:0]] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= frame_mem[rd_cnt[AW-1:0]];
    end
  end

  lfr_out_stage u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (ld_out),
    .res             (res),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_byte      (frame_byte),
    .byte_index      (byte_index),
    .last            (last),
    .crc_error       (crc_error),
    .bad_frame_count (bad_frame_count)
  );

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ld_out |-> out_free)
    else $error("result loaded into a full output register");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (pos < PW'(MAX_FRAME_BYTES)) && (needed <= PW'(MAX_FRAME_BYTES)))
    else $error("frame position beyond buffer");

  a_read_before_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LD) |-> ($past(state) == ST_RD || $past(state) == ST_LD))
    else $error("output load without a preceding RAM read");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (rd_cnt < needed))
    else $error("read beyond the stored frame");

  a_no_rx_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD || state == ST_LD) |-> !wr_en)
    else $error("frame RAM written during output");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for link_frame_receiver_crc8. Byte streams of good,
// corrupted, truncated and malformed frames mixed with line noise are sent
// under random flow control on both channels. A cycle-level-free predictor
// tracks the frame parser and CRC-8, and every output transfer is checked
// against the oldest predicted result. The address registers are changed
// between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfr_pkg::*;

  localparam int MAXB          = MAX_FRAME_BYTES_DEF;
  localparam int LATENCY_PAD   = 12;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int PHASE_BYTES   = 35;

  // DUT connections
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            frame_byte;
  logic [5:0]            byte_index;
  logic                  last;
  logic                  crc_error;
  logic [15:0]           bad_frame_count;

  // stimulus and bookkeeping
  logic [7:0]  link_bytes[$];
  res_t        due_results[$];
  int          pushed_count = 0;
  int          taken_count = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          settings_used = 1;
  bit          in_took = 1'b0;
  bit          no_gaps = 1'b0;

  // predictor state and its copy of the address registers
  logic [7:0]  match_addr[4];
  logic [7:0]  frame_buf[MAXB];
  int          rx_pos = 0;
  int          frame_len = 0;
  logic [7:0]  run_crc = 8'h00;
  logic [15:0] reject_cnt = 16'h0000;
  int          good_frames = 0;
  int          bad_frames = 0;
  int          counter_wraps = 0;

  link_frame_receiver_crc8 dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_byte      (frame_byte),
    .byte_index      (byte_index),
    .last            (last),
    .crc_error       (crc_error),
    .bad_frame_count (bad_frame_count)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // CRC-8 over one byte, MSB first, bit-serial form
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[7] ^ data[k];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic expect_result(input logic [7:0] b, input int idx, input bit fin,
                               input bit err);
    res_t r;
    r.frame_byte      = b;
    r.byte_index      = idx[5:0];
    r.last            = fin;
    r.crc_error       = err;
    r.bad_frame_count = reject_cnt;
    due_results.push_back(r);
  endtask

  // frame parser: one accepted byte in, predicted results queued
  task automatic absorb_byte(input logic [7:0] b);
    if (rx_pos == 0) begin
      if (b == match_addr[REG_ADDR_FC] || b == match_addr[REG_ADDR_AIR] ||
          b == match_addr[REG_ADDR_RX] || b == match_addr[REG_ADDR_TX]) begin
        frame_buf[0] = b;
        rx_pos       = 1;
        run_crc      = 8'h00;
      end
    end else if (rx_pos == 1) begin
      // bad length drops back to idle; the byte is not retried as an address
      if (b < MIN_LEN || b > MAXB - 2) begin
        rx_pos = 0;
      end else begin
        frame_buf[1] = b;
        rx_pos       = 2;
        frame_len    = b + 2;
        run_crc      = 8'h00;
      end
    end else begin
      frame_buf[rx_pos] = b;
      rx_pos++;
      if (rx_pos < frame_len) begin
        run_crc = crc8_d5(run_crc, b);
      end else begin
        rx_pos = 0;
        if (run_crc == b) begin
          good_frames++;
          for (int i = 0; i < frame_len; i++) begin
            expect_result(frame_buf[i], i, i == frame_len - 1, 1'b0);
          end
        end else begin
          bad_frames++;
          if (reject_cnt == 16'hFFFF) begin
            counter_wraps++;
          end
          reject_cnt = reject_cnt + 16'd1;
          expect_result(8'h00, 0, 1'b1, 1'b1);
        end
      end
    end
  endtask

  // sender: next byte at the falling edge once the slot is free
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (link_bytes.size() != 0 && (no_gaps || $urandom_range(99) >= 38)) begin
        rx_byte  <= link_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        rx_byte  <= 8'($urandom);
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 38);
  end

  // transfers on both channels, sampled at the rising edge
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        absorb_byte(rx_byte);
        taken_count++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result: byte %02h idx %0d last %0b err %0b count %0d",
                     $time, frame_byte, byte_index, last, crc_error, bad_frame_count);
          end
        end else begin
          want = due_results.pop_front();
          if (want.frame_byte !== frame_byte || want.byte_index !== byte_index ||
              want.last !== last || want.crc_error !== crc_error ||
              want.bad_frame_count !== bad_frame_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch: want byte %02h idx %0d last %0b err %0b cnt %0d",
                       $time, want.frame_byte, want.byte_index, want.last,
                       want.crc_error, want.bad_frame_count);
              $display("                      got  byte %02h idx %0d last %0b err %0b cnt %0d",
                       frame_byte, byte_index, last, crc_error, bad_frame_count);
            end
          end
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    pushed_count++;
  endtask

  // whole frame; stripes gives a 00/FF payload instead of random bytes
  task automatic queue_frame(input logic [7:0] addr, input int len, input bit crc_ok,
                             input bit stripes);
    logic [7:0] crc;
    logic [7:0] d;
    crc = 8'h00;
    queue_byte(addr);
    queue_byte(len[7:0]);
    for (int k = 0; k < len - 1; k++) begin
      d   = stripes ? (k[0] ? 8'hFF : 8'h00) : 8'($urandom);
      crc = crc8_d5(crc, d);
      queue_byte(d);
    end
    queue_byte(crc_ok ? crc : crc ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    match_addr[idx] = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_addresses(input logic [7:0] a0, input logic [7:0] a1,
                               input logic [7:0] a2, input logic [7:0] a3);
    write_reg(REG_ADDR_FC, a0);
    write_reg(REG_ADDR_AIR, a1);
    write_reg(REG_ADDR_RX, a2);
    write_reg(REG_ADDR_TX, a3);
    settings_used++;
  endtask

  task automatic await_drain();
    while (taken_count != pushed_count || due_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // sender holds off until all results are in and the parser is idle
  task automatic settle_idle();
    await_drain();
    while (rx_pos != 0) begin
      // zero ends a pending length check, or fills out an open frame
      queue_byte(8'h00);
      await_drain();
    end
    repeat (LATENCY_PAD) @(negedge clk);
  endtask

  // mostly well-formed frames, some corrupt, truncated or malformed, some noise
  task automatic random_traffic(input int budget);
    int         start;
    int         pick;
    int         len;
    logic [7:0] a;
    start = pushed_count;
    while (pushed_count - start < budget) begin
      pick = $urandom_range(99);
      a    = match_addr[$urandom_range(3)];
      len  = ($urandom_range(19) == 0) ? $urandom_range(9, MAXB - 2) : $urandom_range(2, 8);
      if (pick < 60) begin
        queue_frame(a, len, 1'b1, 1'b0);
      end else if (pick < 75) begin
        queue_frame(a, len, 1'b0, 1'b0);
      end else if (pick < 83) begin
        queue_byte(a);
        queue_byte($urandom_range(1) ? 8'($urandom_range(1)) : 8'($urandom_range(MAXB - 1, 255)));
      end else if (pick < 91) begin
        // truncated: the following bytes carry on inside this frame
        queue_byte(a);
        queue_byte(len[7:0]);
        repeat ($urandom_range(0, len - 1)) queue_byte(8'($urandom));
      end else begin
        queue_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    match_addr[REG_ADDR_FC]  = ADDR_FC_RST;
    match_addr[REG_ADDR_AIR] = ADDR_AIR_RST;
    match_addr[REG_ADDR_RX]  = ADDR_RX_RST;
    match_addr[REG_ADDR_TX]  = ADDR_TX_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset addresses: noise, each address, bad crc, bad lengths
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h55);
    queue_frame(ADDR_FC_RST, 2, 1'b1, 1'b0);
    queue_frame(ADDR_AIR_RST, 3, 1'b1, 1'b0);
    queue_frame(ADDR_RX_RST, 2, 1'b1, 1'b0);
    queue_frame(ADDR_TX_RST, 4, 1'b0, 1'b0);
    queue_byte(ADDR_FC_RST);
    queue_byte(8'd1);
    queue_byte(ADDR_FC_RST);
    queue_byte(8'd0);
    queue_byte(ADDR_AIR_RST);
    queue_byte(8'(MAXB - 1));
    queue_byte(ADDR_RX_RST);
    queue_byte(8'hFF);
    // length byte equal to an address must not open a new frame
    queue_byte(ADDR_TX_RST);
    queue_byte(ADDR_AIR_RST);
    queue_byte(8'd2);
    queue_byte(8'h11);
    queue_byte(8'h22);
    // longest frame, payload of alternating 00/FF
    queue_frame(ADDR_TX_RST, MAXB - 2, 1'b1, 1'b1);
    settle_idle();

    // extreme address values
    set_addresses(8'h00, 8'hFF, 8'h5A, 8'hA5);
    random_traffic(PHASE_BYTES);
    settle_idle();

    // random addresses, no idling on either side
    set_addresses(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    no_gaps = 1'b1;
    random_traffic(PHASE_BYTES);
    settle_idle();
    no_gaps = 1'b0;

    // back to the default addresses
    set_addresses(ADDR_FC_RST, ADDR_AIR_RST, ADDR_RX_RST, ADDR_TX_RST);
    random_traffic(PHASE_BYTES);
    settle_idle();

    $display("Sent %0d link bytes: %0d good and %0d rejected frames, %0d results checked,",
             taken_count, good_frames, bad_frames, results_seen);
    $display("over %0d address settings; reject counter wrapped %0d time(s), %0d mismatches",
             settings_used, counter_wraps, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
